### design/load_cell_serial_weigher_macros.svh
// ----------------------------------------------------------------------------
// Load cell serial weigher assertion macros
// Clocked assertion wrappers with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_SERIAL_WEIGHER_MACROS_SVH
`define LOAD_CELL_SERIAL_WEIGHER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a condition on every clock edge outside reset
`define LCSW_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("load cell weigher assertion failed");
// Check that a condition implies another in the same cycle
`define LCSW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("load cell weigher assertion failed");
`else
`define LCSW_ASSERT(label, clk, rst, cond)
`define LCSW_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

### design/lcsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell serial weigher package
// Shared constants, register indexes and interface structs.
// ----------------------------------------------------------------------------
package lcsw_pkg;

   localparam int DATA_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 25;
   localparam int WEIGHT_BITS = 25;
   localparam int RAW_OUT_BITS = 24;
   localparam int DIVISOR_BITS = 16;
   localparam int TARE_LIMIT_BITS = 24;

   // largest weight magnitude a result can carry
   localparam int WEIGHT_LIMIT = 16777215;

   localparam logic [DIVISOR_BITS-1:0] SCALE_DIVISOR_RESET = 16'd380;
   localparam logic [TARE_LIMIT_BITS-1:0] TARE_LIMIT_RESET = 24'd25000;
   localparam logic signed [WEIGHT_BITS-1:0] MAX_WEIGHT_RESET = 25'sd5000;
   localparam logic signed [WEIGHT_BITS-1:0] REJECT_LOW_RESET = 25'sd397;
   localparam logic signed [WEIGHT_BITS-1:0] REJECT_HIGH_RESET = 25'sd398;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCALE_DIVISOR = 3'd0,
      CSR_TARE_LIMIT    = 3'd1,
      CSR_MAX_WEIGHT    = 3'd2,
      CSR_REJECT_LOW    = 3'd3,
      CSR_REJECT_HIGH   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIVISOR_BITS-1:0]         scale_divisor;
      logic [TARE_LIMIT_BITS-1:0]      tare_limit;
      logic signed [WEIGHT_BITS-1:0]   max_weight;
      logic signed [WEIGHT_BITS-1:0]   reject_low;
      logic signed [WEIGHT_BITS-1:0]   reject_high;
   } cfg_type;

   // per-tick control that travels with each queued word
   typedef struct packed {
      logic clock_line;
      logic done;
   } tick_flags_type;

endpackage

### design/lcsw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell serial weigher front end
// Runs the serial clock sequencer per tick and queues each tick's word.
// ----------------------------------------------------------------------------
module lcsw_front #(
   parameter int DATA_BITS = lcsw_pkg::DATA_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_data_line,
   output logic                        push_valid,
   input  logic                        push_ready,
   output lcsw_pkg::tick_flags_type    push_flags,
   output logic [DATA_BITS-1:0]        push_raw
);

   localparam int PULSE_BITS = $clog2(DATA_BITS + 1);

   typedef enum logic [1:0] {
      FR_WAIT  = 2'b01,
      FR_SHIFT = 2'b10
   } front_state_type;

   front_state_type            phase_ff, phase_in;
   logic [PULSE_BITS-1:0]      pulse_ff, pulse_in;
   logic                       clk_ff, clk_in;
   logic [DATA_BITS-1:0]       shift_ff, shift_in;
   lcsw_pkg::tick_flags_type   flags;
   logic                       accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign push_flags = flags;
   assign push_raw   = shift_in;

   // sequence the serial clock and shift in the data line
   always_comb begin
      phase_in = phase_ff;
      pulse_in = pulse_ff;
      clk_in   = clk_ff;
      shift_in = shift_ff;
      flags    = '0;
      case (phase_ff)
         FR_SHIFT: begin
            if (!clk_ff) begin
               clk_in           = 1'b1;
               flags.clock_line = 1'b1;
            end else begin
               clk_in = 1'b0;
               if (pulse_ff < PULSE_BITS'(DATA_BITS)) begin
                  shift_in = {shift_ff[DATA_BITS-2:0], req_data_line};
               end
               pulse_in = pulse_ff + PULSE_BITS'(1);
               // gain select pulse closes the conversion
               if (pulse_ff == PULSE_BITS'(DATA_BITS)) begin
                  flags.done = 1'b1;
                  phase_in   = FR_WAIT;
                  pulse_in   = '0;
               end
            end
         end
         default: begin
            phase_in = FR_WAIT;
            clk_in   = 1'b0;
            if (!req_data_line) begin
               phase_in = FR_SHIFT;
               pulse_in = '0;
               shift_in = '0;
            end
         end
      endcase
   end

   // advance on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= FR_WAIT;
         pulse_ff <= '0;
         clk_ff   <= 1'b0;
         shift_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pulse_ff <= pulse_in;
         clk_ff   <= clk_in;
         shift_ff <= shift_in;
      end
   end

endmodule

### design/lcsw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell serial weigher queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module lcsw_queue #(
   parameter int WIDTH = 2 + lcsw_pkg::DATA_BITS_DEFAULT,
   parameter int DEPTH = lcsw_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [WIDTH-1:0]  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [WIDTH-1:0]  pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wptr_ff, wptr_in;
   logic [PTR_BITS-1:0]  rptr_ff, rptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // wrap pointers and track the fill level
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

### design/lcsw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell serial weigher back end
// Takes tare, divides the tared reading and filters the weight.
// ----------------------------------------------------------------------------
module lcsw_back #(
   parameter int DATA_BITS = lcsw_pkg::DATA_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lcsw_pkg::cfg_type                       cfg,
   input  logic                                    pop_valid,
   output logic                                    pop_ready,
   input  lcsw_pkg::tick_flags_type                pop_flags,
   input  logic [DATA_BITS-1:0]                    pop_raw,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_clock_line,
   output logic signed [lcsw_pkg::WEIGHT_BITS-1:0] rsp_weight_grams,
   output logic                                    rsp_weight_updated,
   output logic                                    rsp_tare_taken,
   output logic [lcsw_pkg::RAW_OUT_BITS-1:0]       rsp_raw_reading
);

   localparam int WB = lcsw_pkg::WEIGHT_BITS;
   localparam int RB = lcsw_pkg::RAW_OUT_BITS;
   localparam int DB = lcsw_pkg::DIVISOR_BITS;
   localparam int CNT_BITS = $clog2(DATA_BITS + 1);
   localparam int NW = (DATA_BITS + 1 > WB + 1) ? DATA_BITS + 1 : WB + 1;
   localparam int CW = (DATA_BITS > lcsw_pkg::TARE_LIMIT_BITS) ?
                       DATA_BITS : lcsw_pkg::TARE_LIMIT_BITS;
   localparam logic signed [NW-1:0] SAT_HI = NW'(lcsw_pkg::WEIGHT_LIMIT);
   localparam logic signed [NW-1:0] SAT_LO = -SAT_HI;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_DIV  = 3'b010,
      BK_FIN  = 3'b100
   } back_state_type;

   back_state_type             st_ff, st_in;
   logic                       tare_pending_ff, tare_pending_in;
   logic [DATA_BITS-1:0]       tare_ff, tare_in;
   logic signed [WB-1:0]       weight_ff, weight_in;
   logic [DATA_BITS-1:0]       raw_ff, raw_in;
   logic                       neg_ff, neg_in;
   logic [DATA_BITS-1:0]       quo_ff, quo_in;
   logic [DB-1:0]              rem_ff, rem_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_clk_ff, out_clk_in;
   logic signed [WB-1:0]       out_weight_ff, out_weight_in;
   logic                       out_upd_ff, out_upd_in;
   logic                       out_tare_ff, out_tare_in;
   logic [RB-1:0]              out_raw_ff, out_raw_in;

   logic                       out_free, load;
   logic [DB-1:0]              div_eff;
   logic signed [DATA_BITS:0]  diff;
   logic [DATA_BITS:0]         diff_mag;
   logic [DB:0]                rem_sh;
   logic                       rem_ge;
   logic signed [NW-1:0]       q_ext, q_val, q_sat;
   logic signed [WB-1:0]       n_w;
   logic                       keep;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (st_ff == BK_IDLE) && out_free;
   assign div_eff   = (cfg.scale_divisor == '0) ? DB'(1) : cfg.scale_divisor;

   // signed difference from tare and its magnitude
   assign diff     = signed'({1'b0, pop_raw}) - signed'({1'b0, tare_ff});
   assign diff_mag = diff[DATA_BITS] ? unsigned'(-diff) : unsigned'(diff);

   // one restoring divide step
   assign rem_sh = {rem_ff, quo_ff[DATA_BITS-1]};
   assign rem_ge = (rem_sh >= {1'b0, div_eff});

   // sign, saturate and filter the quotient
   assign q_ext = signed'(NW'(quo_ff));
   assign q_val = neg_ff ? -q_ext : q_ext;
   always_comb begin
      q_sat = q_val;
      if (q_val > SAT_HI) begin
         q_sat = SAT_HI;
      end else if (q_val < SAT_LO) begin
         q_sat = SAT_LO;
      end
   end
   assign n_w  = signed'(q_sat[WB-1:0]);
   assign keep = (n_w < signed'(cfg.max_weight)) &&
                 !((n_w >= signed'(cfg.reject_low)) && (n_w <= signed'(cfg.reject_high)));

   always_comb begin
      st_in           = st_ff;
      tare_pending_in = tare_pending_ff;
      tare_in         = tare_ff;
      weight_in       = weight_ff;
      raw_in          = raw_ff;
      neg_in          = neg_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      load            = 1'b0;
      out_clk_in      = out_clk_ff;
      out_weight_in   = out_weight_ff;
      out_upd_in      = out_upd_ff;
      out_tare_in     = out_tare_ff;
      out_raw_in      = out_raw_ff;
      case (st_ff)
         BK_DIV: begin
            rem_in = rem_ge ? DB'(rem_sh - {1'b0, div_eff}) : rem_sh[DB-1:0];
            quo_in = {quo_ff[DATA_BITS-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(DATA_BITS - 1)) begin
               st_in = BK_FIN;
            end
         end
         BK_FIN: begin
            // completion word is always a low clock tick
            if (out_free) begin
               load          = 1'b1;
               out_clk_in    = 1'b0;
               out_upd_in    = keep;
               out_tare_in   = 1'b0;
               out_raw_in    = RB'(raw_ff);
               out_weight_in = keep ? n_w : weight_ff;
               if (keep) begin
                  weight_in = n_w;
               end
               st_in = BK_IDLE;
            end
         end
         default: begin
            if (pop_valid && out_free) begin
               if (!pop_flags.done) begin
                  load          = 1'b1;
                  out_clk_in    = pop_flags.clock_line;
                  out_upd_in    = 1'b0;
                  out_tare_in   = 1'b0;
                  out_raw_in    = RB'(raw_ff);
                  out_weight_in = weight_ff;
               end else if (tare_pending_ff &&
                            (CW'(pop_raw) < CW'(cfg.tare_limit))) begin
                  // store tare, weight untouched
                  raw_in          = pop_raw;
                  tare_in         = pop_raw;
                  tare_pending_in = 1'b0;
                  load            = 1'b1;
                  out_clk_in      = pop_flags.clock_line;
                  out_upd_in      = 1'b0;
                  out_tare_in     = 1'b1;
                  out_raw_in      = RB'(pop_raw);
                  out_weight_in   = weight_ff;
               end else begin
                  // start the divide on the magnitude
                  raw_in = pop_raw;
                  neg_in = diff[DATA_BITS];
                  quo_in = diff_mag[DATA_BITS-1:0];
                  rem_in = '0;
                  cnt_in = '0;
                  st_in  = BK_DIV;
               end
            end
         end
      endcase
   end

   // hold the result word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= BK_IDLE;
         tare_pending_ff <= 1'b1;
         tare_ff         <= '0;
         weight_ff       <= '0;
         raw_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         st_ff           <= st_in;
         tare_pending_ff <= tare_pending_in;
         tare_ff         <= tare_in;
         weight_ff       <= weight_in;
         raw_ff          <= raw_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // divider and output payload
   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      out_clk_ff    <= out_clk_in;
      out_weight_ff <= out_weight_in;
      out_upd_ff    <= out_upd_in;
      out_tare_ff   <= out_tare_in;
      out_raw_ff    <= out_raw_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clock_line     = out_clk_ff;
   assign rsp_weight_grams   = out_weight_ff;
   assign rsp_weight_updated = out_upd_ff;
   assign rsp_tare_taken     = out_tare_ff;
   assign rsp_raw_reading    = out_raw_ff;

endmodule

### design/load_cell_serial_weigher.sv
// Ordinary ticks: one word per cycle unless the divider or rsp_ready stalls it;
// a word goes through the queue and the back end's output register. A tick
// that completes a conversion and is not tare gets one restoring divide step
// per cycle; later ticks wait in the queue. Reset is synchronous, active high:
// the configuration resets, tare becomes pending, queue and sequencer clear.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell serial weigher
// Serial converter reader with tare, scaling and weight filtering.
// ----------------------------------------------------------------------------
`include "load_cell_serial_weigher_macros.svh"

module load_cell_serial_weigher #(
   parameter int DATA_BITS = lcsw_pkg::DATA_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = lcsw_pkg::QUEUE_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_data_line,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_clock_line,
   output logic signed [lcsw_pkg::WEIGHT_BITS-1:0] rsp_weight_grams,
   output logic                                    rsp_weight_updated,
   output logic                                    rsp_tare_taken,
   output logic [lcsw_pkg::RAW_OUT_BITS-1:0]       rsp_raw_reading,
   input  logic                                    csr_write_enable,
   input  logic [lcsw_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lcsw_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   localparam int FLAG_BITS = $bits(lcsw_pkg::tick_flags_type);
   localparam int QW = FLAG_BITS + DATA_BITS;

   lcsw_pkg::cfg_type          cfg_ff, cfg_in;
   logic                       f_push_valid, f_push_ready;
   lcsw_pkg::tick_flags_type   f_flags;
   logic [DATA_BITS-1:0]       f_raw;
   logic                       q_pop_valid, q_pop_ready;
   logic [QW-1:0]              q_pop_data;

   // configuration write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (lcsw_pkg::csr_index_type'(csr_index))
            lcsw_pkg::CSR_SCALE_DIVISOR:
               cfg_in.scale_divisor = csr_write_data[lcsw_pkg::DIVISOR_BITS-1:0];
            lcsw_pkg::CSR_TARE_LIMIT:
               cfg_in.tare_limit = csr_write_data[lcsw_pkg::TARE_LIMIT_BITS-1:0];
            lcsw_pkg::CSR_MAX_WEIGHT:  cfg_in.max_weight  = signed'(csr_write_data);
            lcsw_pkg::CSR_REJECT_LOW:  cfg_in.reject_low  = signed'(csr_write_data);
            lcsw_pkg::CSR_REJECT_HIGH: cfg_in.reject_high = signed'(csr_write_data);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_divisor <= lcsw_pkg::SCALE_DIVISOR_RESET;
         cfg_ff.tare_limit    <= lcsw_pkg::TARE_LIMIT_RESET;
         cfg_ff.max_weight    <= lcsw_pkg::MAX_WEIGHT_RESET;
         cfg_ff.reject_low    <= lcsw_pkg::REJECT_LOW_RESET;
         cfg_ff.reject_high   <= lcsw_pkg::REJECT_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcsw_front #(
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_line (req_data_line),
      .push_valid    (f_push_valid),
      .push_ready    (f_push_ready),
      .push_flags    (f_flags),
      .push_raw      (f_raw)
   );

   lcsw_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_data  ({f_flags, f_raw}),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   lcsw_back #(
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .pop_valid          (q_pop_valid),
      .pop_ready          (q_pop_ready),
      .pop_flags          (lcsw_pkg::tick_flags_type'(q_pop_data[QW-1:DATA_BITS])),
      .pop_raw            (q_pop_data[DATA_BITS-1:0]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_clock_line     (rsp_clock_line),
      .rsp_weight_grams   (rsp_weight_grams),
      .rsp_weight_updated (rsp_weight_updated),
      .rsp_tare_taken     (rsp_tare_taken),
      .rsp_raw_reading    (rsp_raw_reading)
   );

   // a conversion ends either as tare or as a weight, never both
   `LCSW_ASSERT(a_tare_or_weight, clock, reset, !(rsp_valid && rsp_weight_updated && rsp_tare_taken))
   // completions only land on low clock ticks
   `LCSW_ASSERT_IMPLIES(a_done_low, clock, reset, rsp_valid && (rsp_weight_updated || rsp_tare_taken), !rsp_clock_line)
   // the reported weight moves only with an accepted weight
   `LCSW_ASSERT_IMPLIES(a_weight_moves, clock, reset, rsp_valid && $past(rsp_valid) && (rsp_weight_grams != $past(rsp_weight_grams)), rsp_weight_updated)

endmodule
